@@ rtl/utdt_pkg.sv @@
// ----------------------------------------------------------------------------
// utdt_pkg
// constants and tables for the unix seconds to calendar date and time core
// ----------------------------------------------------------------------------
package utdt_pkg;

    localparam int IN_W     = 39;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int YEAR_W   = 14;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // saturation span 0001-01-01 00:00:00 .. 9999-12-31 23:59:59
    localparam logic signed [IN_W-1:0] SEC_MIN = -39'sd62135596800;
    localparam logic signed [IN_W-1:0] SEC_MAX = 39'sd253402300799;

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [22:0] DAY_SHIFT    = 23'd1789995;
    localparam logic [24:0] DAYS_PER_400 = 25'd146097;
    localparam logic [27:0] I_SCALE      = 28'd4000;
    localparam logic [17:0] DAYS_PER_4   = 18'd1461;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [11:0] SEC_PER_MIN  = 12'd60;
    localparam logic [3:0]  J_JAN        = 4'd11;

    // reciprocals, rounded up, exact over the value ranges in use
    localparam logic [32:0] RCP_DAY  = 33'(((64'd1 << 42) + 64'd674) / 64'd675);
    localparam logic [25:0] RCP_N    = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
    localparam logic [28:0] RCP_I    = 29'(((64'd1 << 49) + 64'd1461000) / 64'd1461001);
    localparam logic [16:0] RCP_J    = 17'(((64'd1 << 28) + 64'd2446) / 64'd2447);
    localparam logic [17:0] RCP_HOUR = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [12:0] RCP_MIN  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

    // (2447 * j) / 80
    function automatic logic [9:0] month_offset(input logic [3:0] j);
        logic [9:0] r;
        unique case (j)
            4'd0:    r = 10'd0;
            4'd1:    r = 10'd30;
            4'd2:    r = 10'd61;
            4'd3:    r = 10'd91;
            4'd4:    r = 10'd122;
            4'd5:    r = 10'd152;
            4'd6:    r = 10'd183;
            4'd7:    r = 10'd214;
            4'd8:    r = 10'd244;
            4'd9:    r = 10'd275;
            4'd10:   r = 10'd305;
            4'd11:   r = 10'd336;
            4'd12:   r = 10'd367;
            4'd13:   r = 10'd397;
            4'd14:   r = 10'd428;
            default: r = 10'd458;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/unix_seconds_to_date_time_core.sv @@
// ----------------------------------------------------------------------------
// unix_seconds_to_date_time_core
// converts signed unix seconds to gregorian month, day, year and time of day
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_valid, in_stall   | unix_seconds
//   out     | out_valid, out_stall | month, day, year, hour, minute, second
//
// ten register stages, at most one constant-reciprocal multiply deep per stage
// one item accepted per cycle when output flows
// a full stage holds while the stage after it is full and held, so bubbles fill
// reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module unix_seconds_to_date_time_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [utdt_pkg::IN_W-1:0]      unix_seconds,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [utdt_pkg::MONTH_W-1:0]          month,
    output logic [utdt_pkg::DAY_W-1:0]            day,
    output logic [utdt_pkg::YEAR_W-1:0]           year,
    output logic [utdt_pkg::HOUR_W-1:0]           hour,
    output logic [utdt_pkg::MINUTE_W-1:0]         minute,
    output logic [utdt_pkg::SECOND_W-1:0]         second
);
    import utdt_pkg::*;

    localparam int NS = 10;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    // stage 1
    logic signed [IN_W-1:0] s1_sat;
    logic [IN_W-1:0]        s1_t_next;
    logic [IN_W-1:0]        s1_t_reg;
    // stage 2
    logic [64:0]            s2_prod;
    logic [21:0]            s2_days_next;
    logic [21:0]            s2_days_reg;
    logic [16:0]            s2_tlo_reg;
    // stage 3
    logic [38:0]            s3_prod;
    logic [16:0]            s3_sod_next;
    logic [22:0]            s3_l0_next;
    logic [16:0]            s3_sod_reg;
    logic [22:0]            s3_l0_reg;
    // stage 4
    logic [50:0]            s4_nprod;
    logic [34:0]            s4_hprod;
    logic [7:0]             s4_n_next;
    logic [HOUR_W-1:0]      s4_hour_next;
    logic [7:0]             s4_n_reg;
    logic [22:0]            s4_l0_reg;
    logic [16:0]            s4_sod_reg;
    logic [HOUR_W-1:0]      s4_hour_reg;
    // stage 5
    logic [24:0]            s5_cent;
    logic [16:0]            s5_hsec;
    logic [15:0]            s5_l1_next;
    logic [11:0]            s5_remh_next;
    logic [7:0]             s5_n_reg;
    logic [15:0]            s5_l1_reg;
    logic [HOUR_W-1:0]      s5_hour_reg;
    logic [11:0]            s5_remh_reg;
    // stage 6
    logic [24:0]            s6_mprod;
    logic [27:0]            s6_v_next;
    logic [MINUTE_W-1:0]    s6_min_next;
    logic [7:0]             s6_n_reg;
    logic [15:0]            s6_l1_reg;
    logic [HOUR_W-1:0]      s6_hour_reg;
    logic [27:0]            s6_v_reg;
    logic [MINUTE_W-1:0]    s6_min_reg;
    logic [11:0]            s6_remh_reg;
    // stage 7
    logic [56:0]            s7_iprod;
    logic [11:0]            s7_msec;
    logic [6:0]             s7_i_next;
    logic [SECOND_W-1:0]    s7_sec_next;
    logic [7:0]             s7_n_reg;
    logic [15:0]            s7_l1_reg;
    logic [HOUR_W-1:0]      s7_hour_reg;
    logic [MINUTE_W-1:0]    s7_min_reg;
    logic [6:0]             s7_i_reg;
    logic [SECOND_W-1:0]    s7_sec_reg;
    // stage 8
    logic [17:0]            s8_qdays;
    logic [9:0]             s8_l2_next;
    logic [7:0]             s8_n_reg;
    logic [6:0]             s8_i_reg;
    logic [9:0]             s8_l2_reg;
    logic [HOUR_W-1:0]      s8_hour_reg;
    logic [MINUTE_W-1:0]    s8_min_reg;
    logic [SECOND_W-1:0]    s8_sec_reg;
    // stage 9
    logic [15:0]            s9_x;
    logic [32:0]            s9_jprod;
    logic [3:0]             s9_j_next;
    logic [7:0]             s9_n_reg;
    logic [6:0]             s9_i_reg;
    logic [9:0]             s9_l2_reg;
    logic [3:0]             s9_j_reg;
    logic [HOUR_W-1:0]      s9_hour_reg;
    logic [MINUTE_W-1:0]    s9_min_reg;
    logic [SECOND_W-1:0]    s9_sec_reg;
    // stage 10
    logic                   s10_k;
    logic [MONTH_W-1:0]     s10_month_next;
    logic [DAY_W-1:0]       s10_day_next;
    logic [YEAR_W-1:0]      s10_year_next;
    logic [MONTH_W-1:0]     s10_month_reg;
    logic [DAY_W-1:0]       s10_day_reg;
    logic [YEAR_W-1:0]      s10_year_reg;
    logic [HOUR_W-1:0]      s10_hour_reg;
    logic [MINUTE_W-1:0]    s10_min_reg;
    logic [SECOND_W-1:0]    s10_sec_reg;

    // stage enables
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // datapath
    always_comb
    begin
        // saturate and offset to year 1
        if (unix_seconds < SEC_MIN)
        begin
            s1_sat = SEC_MIN;
        end
        else if (unix_seconds > SEC_MAX)
        begin
            s1_sat = SEC_MAX;
        end
        else
        begin
            s1_sat = unix_seconds;
        end
        s1_t_next = s1_sat - SEC_MIN;

        // days = t / 86400 = (t >> 7) / 675
        s2_prod      = 65'(s1_t_reg[IN_W-1:7]) * 65'(RCP_DAY);
        s2_days_next = s2_prod[63:42];

        // seconds of day and shifted julian day
        s3_prod     = 39'(s2_days_reg) * 39'(SEC_PER_DAY);
        s3_sod_next = s2_tlo_reg - s3_prod[16:0];
        s3_l0_next  = 23'(s2_days_reg) + DAY_SHIFT;

        // 400-year cycles and hour
        s4_nprod     = 51'({s3_l0_reg, 2'b00}) * 51'(RCP_N);
        s4_n_next    = s4_nprod[50:43];
        s4_hprod     = 35'(s3_sod_reg) * 35'(RCP_HOUR);
        s4_hour_next = s4_hprod[29+HOUR_W-1:29];

        s5_cent      = 25'(s4_n_reg) * DAYS_PER_400 + 25'd3;
        s5_l1_next   = 16'(s4_l0_reg - s5_cent[24:2]);
        s5_hsec      = 17'(s4_hour_reg) * SEC_PER_HOUR;
        s5_remh_next = 12'(s4_sod_reg - s5_hsec);

        s6_v_next   = (28'(s5_l1_reg) + 28'd1) * I_SCALE;
        s6_mprod    = 25'(s5_remh_reg) * 25'(RCP_MIN);
        s6_min_next = s6_mprod[18+MINUTE_W-1:18];

        s7_iprod    = 57'(s6_v_reg) * 57'(RCP_I);
        s7_i_next   = s7_iprod[55:49];
        s7_msec     = 12'(s6_min_reg) * SEC_PER_MIN;
        s7_sec_next = SECOND_W'(s6_remh_reg - s7_msec);

        s8_qdays   = 18'(s7_i_reg) * DAYS_PER_4;
        s8_l2_next = 10'(18'(s7_l1_reg) + 18'd31 - (s8_qdays >> 2));

        s9_x      = 16'(s8_l2_reg) * 16'd80;
        s9_jprod  = 33'(s9_x) * 33'(RCP_J);
        s9_j_next = s9_jprod[31:28];

        // january and february count to the next year
        s10_k          = s9_j_reg >= J_JAN;
        s10_day_next   = DAY_W'(s9_l2_reg - month_offset(s9_j_reg));
        s10_month_next = s10_k ? MONTH_W'(s9_j_reg - 4'd10) : MONTH_W'(s9_j_reg + 4'd2);
        s10_year_next  = YEAR_W'(14'(s9_n_reg - 8'd49) * 14'd100)
                       + YEAR_W'(s9_i_reg) + YEAR_W'(s10_k);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_t_reg <= s1_t_next;
        end
        if (en[1])
        begin
            s2_days_reg <= s2_days_next;
            s2_tlo_reg  <= s1_t_reg[16:0];
        end
        if (en[2])
        begin
            s3_sod_reg <= s3_sod_next;
            s3_l0_reg  <= s3_l0_next;
        end
        if (en[3])
        begin
            s4_n_reg    <= s4_n_next;
            s4_l0_reg   <= s3_l0_reg;
            s4_sod_reg  <= s3_sod_reg;
            s4_hour_reg <= s4_hour_next;
        end
        if (en[4])
        begin
            s5_n_reg    <= s4_n_reg;
            s5_l1_reg   <= s5_l1_next;
            s5_hour_reg <= s4_hour_reg;
            s5_remh_reg <= s5_remh_next;
        end
        if (en[5])
        begin
            s6_n_reg    <= s5_n_reg;
            s6_l1_reg   <= s5_l1_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_v_reg    <= s6_v_next;
            s6_min_reg  <= s6_min_next;
            s6_remh_reg <= s5_remh_reg;
        end
        if (en[6])
        begin
            s7_n_reg    <= s6_n_reg;
            s7_l1_reg   <= s6_l1_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_min_reg  <= s6_min_reg;
            s7_i_reg    <= s7_i_next;
            s7_sec_reg  <= s7_sec_next;
        end
        if (en[7])
        begin
            s8_n_reg    <= s7_n_reg;
            s8_i_reg    <= s7_i_reg;
            s8_l2_reg   <= s8_l2_next;
            s8_hour_reg <= s7_hour_reg;
            s8_min_reg  <= s7_min_reg;
            s8_sec_reg  <= s7_sec_reg;
        end
        if (en[8])
        begin
            s9_n_reg    <= s8_n_reg;
            s9_i_reg    <= s8_i_reg;
            s9_l2_reg   <= s8_l2_reg;
            s9_j_reg    <= s9_j_next;
            s9_hour_reg <= s8_hour_reg;
            s9_min_reg  <= s8_min_reg;
            s9_sec_reg  <= s8_sec_reg;
        end
        if (en[9])
        begin
            s10_month_reg <= s10_month_next;
            s10_day_reg   <= s10_day_next;
            s10_year_reg  <= s10_year_next;
            s10_hour_reg  <= s9_hour_reg;
            s10_min_reg   <= s9_min_reg;
            s10_sec_reg   <= s9_sec_reg;
        end
    end

    assign month  = s10_month_reg;
    assign day    = s10_day_reg;
    assign year   = s10_year_reg;
    assign hour   = s10_hour_reg;
    assign minute = s10_min_reg;
    assign second = s10_sec_reg;

endmodule
